// ===== rtl/qdfr_pkg.sv =====
// Package for the quantized difference filter response block.
// Holds operation codes, configuration indexes and the controller/datapath
// command and status structs; depends on nothing.
package qdfr_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_WR_PIXEL  = 2'd0,
        OP_WR_WEIGHT = 2'd1,
        OP_WR_THRESH = 2'd2,
        OP_COMPUTE   = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_ROWS  = 2'd0;
    localparam logic [1:0] CFG_FILTER_ROWS = 2'd1;
    localparam logic [1:0] CFG_FILTER_COLS = 2'd2;
    localparam logic [1:0] CFG_NUM_BINS    = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int ROWS_W      = 9;
    localparam int SIDE_CFG_W  = 5;
    localparam int BINS_CFG_W  = 3;
    localparam int POS_W       = 8;
    localparam int POS_BIT_W   = 3;
    localparam int DATA_W      = 16;
    localparam int RESP_W      = 24;

    // Address register operations
    typedef enum logic [3:0] {
        ACC_HOLD,
        ACC_DOUBLE,       // acc = 2*acc
        ACC_HORNER,       // acc += rows when the current column bit is set
        ACC_ADD_OROW,     // acc += out_row, also sets the column pointer
        ACC_COL_STEP,     // acc += rows, walk toward the centre column
        ACC_ADD_MR,       // acc += centre row offset
        ACC_LOAD_COLPTR,  // acc = column pointer
        ACC_TAP_STEP      // issue one tap, advance to the next tap address
    } acc_op_t;

    typedef struct packed {
        logic    take;
        acc_op_t acc_op;
        logic    centre_load;
        logic    load_out;
    } qdfr_cmd_t;

    typedef struct packed {
        logic empty;
        logic horner_last;
        logic mc_zero;
        logic tap_last;
        logic pipe_empty;
    } qdfr_status_t;

    // Index width for a store of the given depth, at least one bit
    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== rtl/quantized_difference_filter_response.sv =====
// Top level of the quantized difference filter response block.
// Joins the sequencer qdfr_ctrl and the datapath qdfr_dp; uses qdfr_pkg.

// A write item (pixel, Q8.8 weight or threshold) is taken while the block
// stays idle and gives no result; the image store is column-major with
// image_rows as the stride, the weight store is plane-major, then column,
// then row. A compute item returns one 24-bit Q16.8 response: for every
// tap, the tap pixel minus the window centre pixel is binned by magnitude
// against the thresholds and picks a weight plane, and the picked weights
// are summed exactly. A compute item forms out_col*image_rows modulo the
// image size by shift-and-add, adds out_row, steps to the centre column and
// row, fetches the centre pixel, walks the taps and drains the five-stage
// tap pipeline; an empty filter goes straight to the result. The tap walk
// is paced by the single image read port, which serves one tap a cycle.
// One item is worked on at a time; a new item can be accepted while a
// result still waits in the output register. The stores are not cleared
// after reset, so no clearing pass is needed; reading a never-written
// entry gives an undefined response.
// Configuration writes are taken every cycle and must only come while the
// block is idle.
module quantized_difference_filter_response
    import qdfr_pkg::*;
#(
    parameter int MAX_BINS        = 4,
    parameter int IMAGE_WORDS     = 65536,
    parameter int MAX_FILTER_SIDE = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               operation,
    input  logic [DATA_W-1:0]        address,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         out_row,
    input  logic [POS_W-1:0]         out_col,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [RESP_W-1:0] response,
    // configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    qdfr_cmd_t    cmd;
    qdfr_status_t status;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    qdfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    qdfr_dp #(
        .MAX_BINS        (MAX_BINS),
        .IMAGE_WORDS     (IMAGE_WORDS),
        .MAX_FILTER_SIDE (MAX_FILTER_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .address   (address),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .cmd       (cmd),
        .status    (status),
        .response  (response)
    );

    // A compute transfer makes the block busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op_t'(operation) == OP_COMPUTE) |=> in_stall)
        else $error("compute item did not occupy the block");

    // A write transfer leaves the block free for the next item
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op_t'(operation) != OP_COMPUTE) |=> !in_stall)
        else $error("write item held the block busy");

    // A fresh result only follows a cycle of work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a compute item in progress");

endmodule

// ===== rtl/qdfr_ctrl.sv =====
// Sequencer of the quantized difference filter response block.
// Steps the datapath through address setup, tap walk and drain; uses qdfr_pkg.
module qdfr_ctrl
    import qdfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   operation,
    input  logic         out_stall,
    input  qdfr_status_t status,
    output qdfr_cmd_t    cmd,
    output logic         in_stall,
    output logic         out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DBL,
        S_ADD,
        S_ORW,
        S_CCOL,
        S_CROW,
        S_CRD,
        S_CWAIT,
        S_TAP,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd.take        = 1'b0;
        cmd.acc_op      = ACC_HOLD;
        cmd.centre_load = 1'b0;
        cmd.load_out    = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && op_t'(operation) == OP_COMPUTE)
                    state_next = S_DBL;
            end
            S_DBL:
            begin
                if (status.empty)
                    state_next = S_DONE;
                else
                begin
                    cmd.acc_op = ACC_DOUBLE;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.acc_op = ACC_HORNER;
                state_next = status.horner_last ? S_ORW : S_DBL;
            end
            S_ORW:
            begin
                cmd.acc_op = ACC_ADD_OROW;
                state_next = S_CCOL;
            end
            S_CCOL:
            begin
                if (status.mc_zero)
                    state_next = S_CROW;
                else
                    cmd.acc_op = ACC_COL_STEP;
            end
            S_CROW:
            begin
                cmd.acc_op = ACC_ADD_MR;
                state_next = S_CRD;
            end
            S_CRD:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                cmd.centre_load = 1'b1;
                cmd.acc_op      = ACC_LOAD_COLPTR;
                state_next      = S_TAP;
            end
            S_TAP:
            begin
                cmd.acc_op = ACC_TAP_STEP;
                if (status.tap_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (status.pipe_empty)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/qdfr_dp.sv =====
// Datapath of the quantized difference filter response block.
// Holds configuration, the image, weight and threshold stores, the modular
// address unit and the tap pipeline; uses qdfr_pkg.
module qdfr_dp
    import qdfr_pkg::*;
#(
    parameter int MAX_BINS        = 4,
    parameter int IMAGE_WORDS     = 65536,
    parameter int MAX_FILTER_SIDE = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic [1:0]                   operation,
    input  logic [DATA_W-1:0]            address,
    input  logic signed [DATA_W-1:0]     value,
    input  logic [POS_W-1:0]             out_row,
    input  logic [POS_W-1:0]             out_col,
    input  qdfr_cmd_t                    cmd,
    output qdfr_status_t                 status,
    output logic signed [RESP_W-1:0]     response
);

    localparam int WEIGHT_WORDS = (2 * MAX_BINS + 1) * MAX_FILTER_SIDE * MAX_FILTER_SIDE;
    localparam int IADDR_W      = idx_w(IMAGE_WORDS);
    localparam int WADDR_W      = idx_w(WEIGHT_WORDS);
    localparam int BIN_W        = idx_w(MAX_BINS + 1);
    localparam int PLANE_W      = idx_w(2 * MAX_BINS + 1);
    localparam int SIDE_W       = idx_w(MAX_FILTER_SIDE + 1);
    localparam int XY_W         = idx_w(MAX_FILTER_SIDE);
    localparam int AREA_W       = idx_w(MAX_FILTER_SIDE * MAX_FILTER_SIDE + 1);
    localparam int CMP_W        = DATA_W + 2;
    localparam logic [IADDR_W:0] MOD_W = (IADDR_W + 1)'(IMAGE_WORDS);

    // Configuration registers
    logic [ROWS_W-1:0]     image_rows_reg;
    logic [SIDE_CFG_W-1:0] filter_rows_reg;
    logic [SIDE_CFG_W-1:0] filter_cols_reg;
    logic [BINS_CFG_W-1:0] num_bins_reg;

    // Stores
    logic signed [DATA_W-1:0] img_mem [IMAGE_WORDS];
    logic signed [DATA_W-1:0] wt_mem  [WEIGHT_WORDS];
    logic signed [DATA_W-1:0] thr_reg [MAX_BINS + 1];

    // Item geometry
    logic [POS_W-1:0]       orow_reg;
    logic [POS_W-1:0]       ocol_reg;
    logic [SIDE_W-1:0]      fr_reg;
    logic [SIDE_W-1:0]      fc_reg;
    logic [SIDE_W-1:0]      mr_reg;
    logic [SIDE_W-1:0]      mccnt_reg;
    logic [BIN_W-1:0]       n_reg;
    logic [IADDR_W-1:0]     rows_reg;
    logic signed [CMP_W-1:0] limit_reg;
    logic                   empty_reg;
    logic [AREA_W-1:0]      area_reg;
    logic [POS_BIT_W-1:0]   bitcnt_reg;
    logic [XY_W-1:0]        xf_reg;
    logic [XY_W-1:0]        yf_reg;
    logic [AREA_W-1:0]      tap_reg;

    // Address unit
    logic [IADDR_W-1:0] acc_reg;
    logic [IADDR_W-1:0] acc_next;
    logic [IADDR_W-1:0] colptr_reg;
    logic [IADDR_W-1:0] colptr_next;
    logic [IADDR_W-1:0] mod_a_sum;
    logic [IADDR_W-1:0] mod_b_sum;
    logic [IADDR_W-1:0] mod_a_arg;

    // Tap pipeline
    logic signed [DATA_W-1:0] pix_rd_reg;
    logic signed [DATA_W-1:0] centre_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AREA_W-1:0]        tap1_reg, tap2_reg, tap3_reg;
    logic                     neg2_reg;
    logic [DATA_W:0]          mag2_reg;
    logic [PLANE_W-1:0]       plane3_reg;
    logic [PLANE_W-1:0]       plane_next;
    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [RESP_W-1:0] sum_reg;
    logic signed [RESP_W-1:0] response_reg;

    // Item decode
    op_t                op;
    logic [31:0]        addr_wide;
    logic               tap_issue;
    logic               row_last;
    logic               col_last;
    logic [SIDE_W-1:0]  fr_sat;
    logic [SIDE_W-1:0]  fc_sat;
    logic [SIDE_W:0]    fr_half;
    logic [SIDE_W:0]    fc_half;
    logic [BIN_W-1:0]   n_sat;
    logic [31:0]        rows_wide;
    logic [31:0]        rows_red;
    logic signed [DATA_W:0] diff1;
    logic [WADDR_W-1:0] waddr3;

    function automatic logic [IADDR_W-1:0] mod_add(input logic [IADDR_W-1:0] a,
                                                   input logic [IADDR_W-1:0] b);
        logic [IADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_W)
            s = s - MOD_W;
        return s[IADDR_W-1:0];
    endfunction

    assign op        = op_t'(operation);
    assign addr_wide = 32'(address);
    assign tap_issue = (cmd.acc_op == ACC_TAP_STEP);
    assign row_last  = (SIDE_W'(yf_reg) == fr_reg - SIDE_W'(1));
    assign col_last  = (SIDE_W'(xf_reg) == fc_reg - SIDE_W'(1));

    // Clamp the geometry and bin-count registers to what the stores can hold
    assign fr_sat  = (32'(filter_rows_reg) > MAX_FILTER_SIDE) ? SIDE_W'(MAX_FILTER_SIDE)
                                                             : SIDE_W'(filter_rows_reg);
    assign fc_sat  = (32'(filter_cols_reg) > MAX_FILTER_SIDE) ? SIDE_W'(MAX_FILTER_SIDE)
                                                             : SIDE_W'(filter_cols_reg);
    assign n_sat   = (32'(num_bins_reg) > MAX_BINS) ? BIN_W'(MAX_BINS) : BIN_W'(num_bins_reg);
    assign fr_half = ({1'b0, fr_sat} + (SIDE_W + 1)'(1)) >> 1;
    assign fc_half = ({1'b0, fc_sat} + (SIDE_W + 1)'(1)) >> 1;
    assign rows_wide = 32'(image_rows_reg);
    assign rows_red  = (rows_wide >= 32'(IMAGE_WORDS)) ? rows_wide - 32'(IMAGE_WORDS)
                                                      : rows_wide;

    // Modular address unit: one for the tap pointer, one for the column pointer
    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_DOUBLE:   mod_a_arg = acc_reg;
            ACC_HORNER:   mod_a_arg = ocol_reg[bitcnt_reg] ? rows_reg : '0;
            ACC_ADD_OROW: mod_a_arg = IADDR_W'(orow_reg);
            ACC_COL_STEP: mod_a_arg = rows_reg;
            ACC_ADD_MR:   mod_a_arg = IADDR_W'(mr_reg);
            ACC_TAP_STEP: mod_a_arg = IADDR_W'(1);
            default:      mod_a_arg = '0;
        endcase
    end

    assign mod_a_sum = mod_add(acc_reg, mod_a_arg);
    assign mod_b_sum = mod_add(colptr_reg, rows_reg);

    always_comb
    begin
        acc_next    = acc_reg;
        colptr_next = colptr_reg;
        unique case (cmd.acc_op)
            ACC_HOLD:        acc_next = acc_reg;
            ACC_DOUBLE,
            ACC_HORNER,
            ACC_COL_STEP,
            ACC_ADD_MR:      acc_next = mod_a_sum;
            ACC_ADD_OROW:
            begin
                acc_next    = mod_a_sum;
                colptr_next = mod_a_sum;
            end
            ACC_LOAD_COLPTR: acc_next = colptr_reg;
            ACC_TAP_STEP:
            begin
                if (row_last)
                begin
                    acc_next    = mod_b_sum;
                    colptr_next = mod_b_sum;
                end
                else
                    acc_next = mod_a_sum;
            end
            default:         acc_next = acc_reg;
        endcase
        if (cmd.take && op == OP_COMPUTE)
            acc_next = '0;
    end

    // Bin search: first bin whose bound exceeds the clamped magnitude
    always_comb
    begin
        logic signed [CMP_W-1:0] mag_s;
        logic signed [CMP_W-1:0] mag_cl;
        logic [BIN_W-1:0]        bin;
        logic                    found;
        mag_s  = CMP_W'({1'b0, mag2_reg});
        mag_cl = (mag_s > limit_reg) ? limit_reg : mag_s;
        bin    = n_reg;
        found  = 1'b0;
        for (int k = 0; k <= MAX_BINS; k++)
        begin
            if (!found && BIN_W'(k) <= n_reg && mag_cl < CMP_W'(thr_reg[k]))
            begin
                bin   = BIN_W'(k);
                found = 1'b1;
            end
        end
        plane_next = neg2_reg ? PLANE_W'(n_reg) - PLANE_W'(bin)
                              : PLANE_W'(n_reg) + PLANE_W'(bin);
    end

    assign diff1  = (DATA_W + 1)'(pix_rd_reg) - (DATA_W + 1)'(centre_reg);
    assign waddr3 = WADDR_W'(plane3_reg) * WADDR_W'(area_reg) + WADDR_W'(tap3_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= ROWS_W'(256);
            filter_rows_reg <= SIDE_CFG_W'(1);
            filter_cols_reg <= SIDE_CFG_W'(1);
            num_bins_reg    <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                    CFG_FILTER_ROWS: filter_rows_reg <= cfg_data[SIDE_CFG_W-1:0];
                    CFG_FILTER_COLS: filter_cols_reg <= cfg_data[SIDE_CFG_W-1:0];
                    CFG_NUM_BINS:    num_bins_reg    <= cfg_data[BINS_CFG_W-1:0];
                    default:         num_bins_reg    <= num_bins_reg;
                endcase
            end
            v1_reg <= tap_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Image and weight stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.take && op == OP_WR_PIXEL && addr_wide < 32'(IMAGE_WORDS))
            img_mem[addr_wide[IADDR_W-1:0]] <= value;
        pix_rd_reg <= img_mem[acc_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && op == OP_WR_WEIGHT && addr_wide < 32'(WEIGHT_WORDS))
            wt_mem[addr_wide[WADDR_W-1:0]] <= value;
        w_rd_reg <= wt_mem[waddr3];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && op == OP_WR_THRESH && addr_wide <= 32'(MAX_BINS))
            thr_reg[addr_wide[BIN_W-1:0]] <= value;
    end

    // Item geometry, address unit and tap pipeline payload
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        colptr_reg <= colptr_next;
        area_reg   <= AREA_W'(fr_reg) * AREA_W'(fc_reg);
        if (cmd.take && op == OP_COMPUTE)
        begin
            orow_reg   <= out_row;
            ocol_reg   <= out_col;
            fr_reg     <= fr_sat;
            fc_reg     <= fc_sat;
            mr_reg     <= SIDE_W'(fr_half - (SIDE_W + 1)'(1));
            mccnt_reg  <= SIDE_W'(fc_half - (SIDE_W + 1)'(1));
            n_reg      <= n_sat;
            rows_reg   <= rows_red[IADDR_W-1:0];
            limit_reg  <= CMP_W'(thr_reg[n_sat]) - CMP_W'(1);
            empty_reg  <= (fr_sat == '0) || (fc_sat == '0);
            bitcnt_reg <= POS_BIT_W'(POS_W - 1);
            xf_reg     <= '0;
            yf_reg     <= '0;
            tap_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            if (cmd.acc_op == ACC_HORNER)
                bitcnt_reg <= bitcnt_reg - POS_BIT_W'(1);
            if (cmd.acc_op == ACC_COL_STEP)
                mccnt_reg <= mccnt_reg - SIDE_W'(1);
            if (tap_issue)
            begin
                tap_reg <= tap_reg + AREA_W'(1);
                if (row_last)
                begin
                    yf_reg <= '0;
                    xf_reg <= xf_reg + XY_W'(1);
                end
                else
                    yf_reg <= yf_reg + XY_W'(1);
            end
            if (v4_reg)
                sum_reg <= sum_reg + RESP_W'(w_rd_reg);
        end
        if (cmd.centre_load)
            centre_reg <= pix_rd_reg;
        tap1_reg   <= tap_reg;
        tap2_reg   <= tap1_reg;
        neg2_reg   <= diff1 < 0;
        mag2_reg   <= (diff1 < 0) ? (DATA_W + 1)'(-diff1) : (DATA_W + 1)'(diff1);
        tap3_reg   <= tap2_reg;
        plane3_reg <= plane_next;
        if (cmd.load_out)
            response_reg <= sum_reg;
    end

    assign status.empty       = empty_reg;
    assign status.horner_last = (bitcnt_reg == '0);
    assign status.mc_zero     = (mccnt_reg == '0);
    assign status.tap_last    = row_last && col_last;
    assign status.pipe_empty  = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign response           = response_reg;

endmodule

// ===== dv/quantized_difference_filter_response_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for quantized_difference_filter_response.
// Drives config, store and compute transfers, predicts each untyped response
// with a local filter model and checks all; depends on qdfr_pkg and the RTL.
module quantized_difference_filter_response_tb
    import qdfr_pkg::*;
();

    // Block sizes, kept at the RTL defaults
    localparam int MAX_BINS     = 4;
    localparam int IMAGE_WORDS  = 65536;
    localparam int MAX_SIDE     = 16;
    localparam int WEIGHT_WORDS = (2 * MAX_BINS + 1) * MAX_SIDE * MAX_SIDE;

    // Run shaping: item budget, quiet time after the last response, and a
    // hard stop well above the slowest run
    localparam int ITEM_TARGET  = 1550;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 3000000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = OP_WR_PIXEL;
    logic [DATA_W-1:0]        address   = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic [POS_W-1:0]         out_row   = '0;
    logic [POS_W-1:0]         out_col   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [RESP_W-1:0] response;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = CFG_IMAGE_ROWS;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    quantized_difference_filter_response dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .address   (address),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .response  (response),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the block's stores, with a written flag per entry so that
    // no compute ever touches an entry the block holds as undefined
    logic signed [15:0] pixel_mem  [IMAGE_WORDS];
    logic signed [15:0] weight_mem [WEIGHT_WORDS];
    logic signed [15:0] thresh_mem [MAX_BINS + 1];
    bit                 pixel_set  [IMAGE_WORDS];
    bit                 weight_set [WEIGHT_WORDS];
    bit                 thresh_set [MAX_BINS + 1];

    // Local copy of the configuration registers, at their reset values
    int rows_cfg  = 256;
    int frows_cfg = 1;
    int fcols_cfg = 1;
    int bins_cfg  = 0;

    // Responses still owed by the block, oldest first
    logic [RESP_W-1:0] response_q[$];

    int mismatches  = 0;
    int items_done  = 0;
    int cycle_count = 0;
    int send_pct    = 16;
    int recv_pct    = 48;

    // Per-phase shaping of write data and compute positions
    int spread_cur  = 0;
    bit min_weights = 1'b0;
    int base_row    = 0;
    int base_col    = 0;

    // Directed stimulus: one row per transfer, expected response typed in
    typedef struct {
        op_t         op;
        logic [15:0] addr;
        logic [15:0] val;
        logic [7:0]  row;
        logic [7:0]  col;
        bit          typed;
        logic [23:0] want;
    } dir_row_t;

    dir_row_t dir_table[$];

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost response ends up here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                 response_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Response monitor: check each transfer against the oldest prediction,
    // then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (response_q.size() == 0)
                log_mismatch($sformatf("response %0d with nothing pending", response));
            else
            begin
                if (response !== response_q[0])
                    log_mismatch($sformatf("response %0d, predicted %0d", response,
                                           $signed(response_q[0])));
                void'(response_q.pop_front());
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    function automatic int eff_side(input int side);
        return (side > MAX_SIDE) ? MAX_SIDE : side;
    endfunction

    function automatic int eff_bins();
        return (bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg;
    endfunction

    // Column-major image address, wrapped to the store size
    function automatic int pixel_addr(input int col, input int row);
        return (col * rows_cfg + row) % IMAGE_WORDS;
    endfunction

    // Filter response at one output position from the local stores
    function automatic int filter_sum(input int orow, input int ocol);
        int fr, fc, n, mr, mc, centre, limit, d, mag, bin, plane, t, sum;
        fr  = eff_side(frows_cfg);
        fc  = eff_side(fcols_cfg);
        n   = eff_bins();
        sum = 0;
        if (fr == 0 || fc == 0)
            return 0;
        mr     = (fr + fr % 2) / 2 - 1;
        mc     = (fc + fc % 2) / 2 - 1;
        centre = pixel_mem[pixel_addr(ocol + mc, orow + mr)];
        limit  = thresh_mem[n];
        limit  = limit - 1;
        for (int xf = 0; xf < fc; xf++)
        begin
            for (int yf = 0; yf < fr; yf++)
            begin
                d   = pixel_mem[pixel_addr(ocol + xf, orow + yf)];
                d   = d - centre;
                mag = (d < 0) ? -d : d;
                if (mag > limit)
                    mag = limit;
                // walk down so the lowest bin whose bound exceeds mag wins
                bin = n;
                for (int k = n; k >= 0; k--)
                begin
                    t = thresh_mem[k];
                    if (mag < t)
                        bin = k;
                end
                plane = (d < 0) ? n - bin : n + bin;
                t     = weight_mem[plane * fr * fc + xf * fr + yf];
                sum  += t;
            end
        end
        return sum;
    endfunction

    // Update the local stores for an accepted transfer; queue the response
    // of a compute. Writes beyond a store are dropped and not counted.
    function automatic void record_item(input op_t op, input logic [15:0] addr,
                                        input logic [15:0] val, input logic [7:0] row,
                                        input logic [7:0] col, input bit typed,
                                        input logic [23:0] want);
        int sum;
        case (op)
            OP_WR_PIXEL:
            begin
                pixel_mem[addr] = val;
                pixel_set[addr] = 1'b1;
                items_done++;
            end
            OP_WR_WEIGHT:
            begin
                if (addr < WEIGHT_WORDS)
                begin
                    weight_mem[addr] = val;
                    weight_set[addr] = 1'b1;
                    items_done++;
                end
            end
            OP_WR_THRESH:
            begin
                if (addr <= MAX_BINS)
                begin
                    thresh_mem[addr] = val;
                    thresh_set[addr] = 1'b1;
                    items_done++;
                end
            end
            default:
            begin
                sum = filter_sum(row, col);
                response_q.push_back(typed ? want : sum[23:0]);
                items_done++;
            end
        endcase
    endfunction

    // Drive one item transfer: idle the sender at random first, then hold
    // the payload until the block takes it. Valid stays high on return so
    // that back-to-back items need no gap; drop it with drop_input.
    task automatic send_item(input op_t op, input logic [15:0] addr,
                             input logic [15:0] val, input logic [7:0] row,
                             input logic [7:0] col, input bit typed,
                             input logic [23:0] want);
        if (items_done < ITEM_TARGET / 3)
        begin
            send_pct = 16;
            recv_pct = 48;
        end
        else if (items_done < 2 * ITEM_TARGET / 3)
        begin
            send_pct = 48;
            recv_pct = 16;
        end
        else
        begin
            send_pct = 0;
            recv_pct = 0;
        end
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        address   <= addr;
        value     <= val;
        out_row   <= row;
        out_col   <= col;
        do
            @(posedge clk);
        while (in_stall);
        record_item(op, addr, val, row, col, typed, want);
    endtask

    task automatic send_write(input op_t op, input logic [15:0] addr,
                              input logic [15:0] val);
        send_item(op, addr, val, 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    function automatic logic [15:0] rand_pixel();
        if (spread_cur == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, spread_cur) - spread_cur / 2);
    endfunction

    function automatic logic [15:0] rand_weight();
        if (min_weights)
            return 16'h8000;
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_thresh();
        if (spread_cur == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, spread_cur) - spread_cur / 4);
    endfunction

    function automatic int near(input int base);
        return (base + $urandom_range(0, 7)) % 256;
    endfunction

    // Fill every store entry this compute will read and that was never
    // written, then issue the compute itself
    task automatic send_compute(input int row, input int col);
        int fr, fc, n, a;
        fr = eff_side(frows_cfg);
        fc = eff_side(fcols_cfg);
        n  = eff_bins();
        if (fr != 0 && fc != 0)
        begin
            for (int k = 0; k <= n; k++)
                if (!thresh_set[k])
                    send_write(OP_WR_THRESH, 16'(k), rand_thresh());
            for (int xf = 0; xf < fc; xf++)
                for (int yf = 0; yf < fr; yf++)
                begin
                    a = pixel_addr(col + xf, row + yf);
                    if (!pixel_set[a])
                        send_write(OP_WR_PIXEL, 16'(a), rand_pixel());
                end
            for (int p = 0; p <= 2 * n; p++)
                for (int t = 0; t < fr * fc; t++)
                begin
                    a = p * fr * fc + t;
                    if (!weight_set[a])
                        send_write(OP_WR_WEIGHT, 16'(a), rand_weight());
                end
        end
        send_item(OP_COMPUTE, 16'($urandom), 16'($urandom), 8'(row), 8'(col), 1'b0, '0);
    endtask

    task automatic drop_input();
        in_valid <= 1'b0;
    endtask

    // Hold until every response is in, then let the block go quiet
    task automatic settle();
        drop_input();
        while (response_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all four registers back to back; valid stays high across them
    task automatic write_config(input int rows, input int fr, input int fc, input int nb);
        put_reg(CFG_IMAGE_ROWS, rows);
        put_reg(CFG_FILTER_ROWS, fr);
        put_reg(CFG_FILTER_COLS, fc);
        put_reg(CFG_NUM_BINS, nb);
        cfg_valid <= 1'b0;
        rows_cfg  = rows;
        frows_cfg = fr;
        fcols_cfg = fc;
        bins_cfg  = nb;
    endtask

    // One random phase: reconfigure while idle, lay down a rising threshold
    // ladder, then mix computes around a home position with rewrites and
    // out-of-range noise. A spread of zero means full-range pixel values.
    task automatic run_phase(input int rows, input int fr, input int fc, input int nb,
                             input int spread, input bit all_min, input int quota);
        int start, results, pick, efr, efc, n, span, step, t;
        settle();
        write_config(rows, fr, fc, nb);
        spread_cur  = spread;
        min_weights = all_min;
        efr         = eff_side(fr);
        efc         = eff_side(fc);
        n           = eff_bins();
        span        = (2 * n + 1) * efr * efc;
        if (span == 0)
            span = WEIGHT_WORDS;
        base_row = $urandom_range(0, 255);
        base_col = $urandom_range(0, 255);

        step = ((spread == 0) ? 32767 : spread) / (n + 1);
        if (step < 1)
            step = 1;
        t = 0;
        for (int k = 0; k <= n; k++)
        begin
            t += $urandom_range(1, step);
            if (t > 32767)
                t = 32767;
            send_write(OP_WR_THRESH, 16'(k), 16'(t));
        end

        start   = items_done;
        results = 0;
        while (items_done - start < quota || results < 4)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // far positions only where the window is cheap to fill
                if (efr * efc <= 16 && $urandom_range(0, 9) == 0)
                    send_compute($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    send_compute(near(base_row), near(base_col));
                results++;
            end
            else if (pick < 72)
            begin
                send_write(OP_WR_PIXEL,
                           16'(pixel_addr(near(base_col) + $urandom_range(0, 15),
                                          near(base_row) + $urandom_range(0, 15))),
                           rand_pixel());
            end
            else if (pick < 82)
            begin
                send_write(OP_WR_WEIGHT, 16'($urandom_range(0, span - 1)), rand_weight());
            end
            else if (pick < 87)
            begin
                send_write(OP_WR_THRESH, 16'($urandom_range(0, MAX_BINS)), rand_thresh());
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_write(OP_WR_WEIGHT, 16'($urandom_range(WEIGHT_WORDS, 65535)),
                                  16'($urandom));
                    1: send_write(OP_WR_THRESH, 16'($urandom_range(MAX_BINS + 1, 65535)),
                                  16'($urandom));
                    default: send_write(OP_WR_PIXEL, 16'($urandom), rand_pixel());
                endcase
            end
        end
    endtask

    function automatic void add_row(input op_t op, input logic [15:0] addr,
                                    input logic [15:0] val, input logic [7:0] row,
                                    input logic [7:0] col, input bit typed,
                                    input logic [23:0] want);
        dir_row_t r;
        r.op    = op;
        r.addr  = addr;
        r.val   = val;
        r.row   = row;
        r.col   = col;
        r.typed = typed;
        r.want  = want;
        dir_table.push_back(r);
    endfunction

    initial
    begin
        // Reset config is 256 rows, a 1x1 filter and no bins, so every
        // compute lands on plane 0 and returns weight 0 unchanged
        add_row(OP_WR_THRESH, 16'd0,     16'd100,  8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_WEIGHT, 16'd0,     16'h7FFF, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_PIXEL,  16'd0,     16'h8000, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'd0,     16'd0,    8'd0,   8'd0,   1'b1, 24'h007FFF);
        add_row(OP_WR_WEIGHT, 16'd0,     16'h8000, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_PIXEL,  16'hFFFF,  16'h7FFF, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'd0,     16'd0,    8'hFF,  8'hFF,  1'b1, 24'hFF8000);
        // writes past the weight and threshold stores must leave them alone
        add_row(OP_WR_WEIGHT, 16'd2304,  16'd1234, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_WEIGHT, 16'hFFFF,  16'd5,    8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_THRESH, 16'd5,     16'd7,    8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_THRESH, 16'hFFFF,  16'hFFFF, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'hFFFF,  16'hFFFF, 8'd0,   8'd0,   1'b1, 24'hFF8000);
        // most negative threshold: the clamp limit drops below every value
        add_row(OP_WR_THRESH, 16'd0,     16'h8000, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'd0,     16'd0,    8'hFF,  8'hFF,  1'b1, 24'hFF8000);
        add_row(OP_WR_PIXEL,  16'h5555,  16'h5555, 8'hAA,  8'h55,  1'b0, '0);
        add_row(OP_WR_PIXEL,  16'hAAAA,  16'hAAAA, 8'h55,  8'hAA,  1'b0, '0);
        add_row(OP_WR_WEIGHT, 16'd0,     16'h5555, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'hAAAA,  16'h5555, 8'h55,  8'h55,  1'b1, 24'h005555);
        add_row(OP_COMPUTE,   16'h5555,  16'hAAAA, 8'hAA,  8'hAA,  1'b1, 24'h005555);
        add_row(OP_WR_WEIGHT, 16'd2303,  16'h2AAA, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_THRESH, 16'd4,     16'd1,    8'd0,   8'd0,   1'b0, '0);
        add_row(OP_WR_THRESH, 16'd0,     16'h7FFF, 8'd0,   8'd0,   1'b0, '0);
        add_row(OP_COMPUTE,   16'd0,     16'd0,    8'd0,   8'd0,   1'b1, 24'h005555);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
            send_item(dir_table[i].op, dir_table[i].addr, dir_table[i].val,
                      dir_table[i].row, dir_table[i].col, dir_table[i].typed,
                      dir_table[i].want);

        // rows, filter rows, filter cols, bins, spread, min weights, quota
        run_phase(16,  3,  3,  2, 64,  1'b0, 180);
        run_phase(1,   2,  5,  4, 200, 1'b0, 160);
        run_phase(0,   0,  4,  1, 64,  1'b0, 50);    // empty filter: zero rows
        run_phase(511, 4,  0,  3, 0,   1'b0, 50);    // empty filter: zero cols
        run_phase(256, 31, 1,  7, 100, 1'b0, 160);   // oversized side, too many bins
        run_phase(37,  2,  16, 4, 0,   1'b0, 200);
        run_phase(16,  16, 16, 0, 40,  1'b1, 120);   // full window at the sum floor
        run_phase(9,   5,  3,  4, 30,  1'b0, 160);
        run_phase(100, 7,  6,  3, 500, 1'b0, 150);
        run_phase(256, 1,  1,  0, 0,   1'b0, 80);

        settle();
        if (mismatches == 0 && response_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qdfr_pkg.sv
rtl/qdfr_ctrl.sv
rtl/qdfr_dp.sv
rtl/quantized_difference_filter_response.sv
dv/quantized_difference_filter_response_tb.sv
